@@ rtl/core/rbw_pkg.sv @@
package rbw_pkg;

   localparam int SAMPLE_W = 24;
   localparam int MAX_WINDOW = 64;
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int WLEN_W = 7;
   localparam int PAIR_W = 2 * SAMPLE_W;
   localparam int SUM_W = 31;
   localparam int CROSS_W = 54;
   localparam int SQ_W = 53;
   localparam int MUL_W = 31;
   localparam int PROD_W = 2 * MUL_W;
   localparam int BETA_W = 32;
   localparam int FRAC_SHIFT = 16;
   localparam int QCNT_W = 5;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
   localparam logic [WLEN_W-1:0] WLEN_MIN = 7'd2;
   localparam logic [WLEN_W-1:0] WLEN_MAX = 7'(MAX_WINDOW);
   localparam logic [BETA_W-1:0] BETA_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [BETA_W-1:0] BETA_NEG_MAX = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_READ, OP_MUL_TB, OP_MUL_BB, OP_MUL_OTB, OP_MUL_OBB,
      OP_UPDATE, OP_MUL_SS, OP_NUM, OP_DEN, OP_ABS, OP_INIT, OP_DIV, OP_FINISH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MUL_TB, ST_MUL_BB, ST_MUL_OTB, ST_MUL_OBB, ST_UPDATE,
      ST_MUL_SS, ST_NUM, ST_DEN, ST_ABS, ST_INIT, ST_DIV, ST_FINISH
   } state_type;

   typedef struct packed {
      logic full;
      logic den_zero;
      logic early_sat;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

@@ rtl/core/rbw_ram.sv @@
module rbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/rbw_ctrl.sv @@
module rbw_ctrl import rbw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output op_type     op
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op = OP_ACCEPT;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            op = OP_READ;
            state_in = ST_MUL_TB;
         end
         ST_MUL_TB: begin
            op = OP_MUL_TB;
            state_in = ST_MUL_BB;
         end
         ST_MUL_BB: begin
            op = OP_MUL_BB;
            state_in = ST_MUL_OTB;
         end
         ST_MUL_OTB: begin
            op = OP_MUL_OTB;
            state_in = ST_MUL_OBB;
         end
         ST_MUL_OBB: begin
            op = OP_MUL_OBB;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            op = OP_UPDATE;
            state_in = ST_MUL_SS;
         end
         ST_MUL_SS: begin
            // window still filling: no result for this item
            if (status.full) begin
               op = OP_MUL_SS;
               state_in = ST_NUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NUM: begin
            op = OP_NUM;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            op = OP_DEN;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            op = OP_ABS;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            op = OP_INIT;
            if (status.den_zero || status.early_sat) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            op = OP_DIV;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               op = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

@@ rtl/core/rbw_dp.sv @@
module rbw_dp import rbw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  op_type              op,
   output status_type          status,
   input  logic [PAIR_W-1:0]   req_tdata,
   input  logic                req_tuser,
   input  logic                csr_we,
   input  logic [WLEN_W-1:0]   csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [BETA_W-1:0]   rsp_tdata,
   output logic [1:0]          rsp_tuser
);
   logic [WLEN_W-1:0]          wlen_ff;
   logic [WLEN_W-1:0]          w_eff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [WLEN_W-1:0]          fill_ff;
   logic signed [SUM_W-1:0]    st_ff, sb_ff;
   logic signed [CROSS_W-1:0]  cross_ff;
   logic [SQ_W-1:0]            sbb_ff;
   logic signed [SAMPLE_W-1:0] t_ff, b_ff, ot_ff, ob_ff;
   logic                       remove_ff;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   prod_ff, wprod_ff, num_ff;
   logic [PROD_W-1:0]          den_ff, mag_ff, r_ff, r_sh;
   logic                       neg_ff, ge, nbit;
   logic [QCNT_W-1:0]          cnt_ff;
   logic [BETA_W-1:0]          q_ff, beta;
   logic                       sat, flat;
   logic                       rsp_valid_ff;
   logic [BETA_W-1:0]          rsp_data_ff;
   logic [1:0]                 rsp_user_ff;
   logic [PAIR_W-1:0]          ram_rdata;
   logic [SLOT_W-1:0]          old_slot;
   logic signed [WLEN_W:0]     w_s;

   always_comb begin
      if (wlen_ff < WLEN_MIN) begin
         w_eff = WLEN_MIN;
      end else if (wlen_ff > WLEN_MAX) begin
         w_eff = WLEN_MAX;
      end else begin
         w_eff = wlen_ff;
      end
   end

   assign w_s = signed'({1'b0, w_eff});
   assign old_slot = slot_ff - w_eff[SLOT_W-1:0];

   rbw_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_WINDOW)) u_ram (
      .clock  (clock),
      .wr_en  (op == OP_UPDATE),
      .wr_addr(slot_ff),
      .wr_data({b_ff, t_ff}),
      .rd_en  (op == OP_READ),
      .rd_addr(old_slot),
      .rd_data(ram_rdata)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op)
         OP_MUL_TB: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(b_ff);
         end
         OP_MUL_BB: begin
            mul_a = MUL_W'(b_ff);
            mul_b = MUL_W'(b_ff);
         end
         OP_MUL_OTB: begin
            mul_a = MUL_W'(ot_ff);
            mul_b = MUL_W'(ob_ff);
         end
         OP_MUL_OBB: begin
            mul_a = MUL_W'(ob_ff);
            mul_b = MUL_W'(ob_ff);
         end
         OP_MUL_SS: begin
            mul_a = st_ff;
            mul_b = sb_ff;
         end
         OP_NUM: begin
            mul_a = sb_ff;
            mul_b = sb_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // numerator bits below the Q16 shift are zero
   assign nbit = cnt_ff[QCNT_W-1] ? mag_ff[cnt_ff[QCNT_W-2:0]] : 1'b0;
   assign r_sh = {r_ff[PROD_W-2:0], nbit};
   assign ge = (r_sh >= den_ff);

   assign flat = (den_ff == '0);
   always_comb begin
      sat = 1'b0;
      beta = neg_ff ? (BETA_W'(0) - q_ff) : q_ff;
      if (status.early_sat) begin
         sat = 1'b1;
      end else if (neg_ff ? (q_ff > BETA_NEG_MAX) : (q_ff > BETA_POS_MAX)) begin
         sat = 1'b1;
      end
      if (sat) begin
         beta = neg_ff ? BETA_NEG_MAX : BETA_POS_MAX;
      end
   end

   assign status.full = (fill_ff >= w_eff);
   assign status.den_zero = flat;
   assign status.early_sat = ({16'b0, mag_ff} >= {den_ff, 16'b0});
   assign status.div_last = (cnt_ff == '0);
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WLEN_RESET;
         slot_ff <= '0;
         fill_ff <= '0;
         st_ff <= '0;
         sb_ff <= '0;
         cross_ff <= '0;
         sbb_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            wlen_ff <= csr_wdata;
            slot_ff <= '0;
            fill_ff <= '0;
            st_ff <= '0;
            sb_ff <= '0;
            cross_ff <= '0;
            sbb_ff <= '0;
         end else begin
            unique case (op)
               OP_ACCEPT: begin
                  if (req_tuser) begin
                     slot_ff <= '0;
                     fill_ff <= '0;
                     st_ff <= '0;
                     sb_ff <= '0;
                     cross_ff <= '0;
                     sbb_ff <= '0;
                  end
               end
               OP_MUL_BB: cross_ff <= cross_ff + CROSS_W'(prod_ff);
               OP_MUL_OTB: sbb_ff <= sbb_ff + prod_ff[SQ_W-1:0];
               OP_MUL_OBB: begin
                  if (remove_ff) begin
                     cross_ff <= cross_ff - CROSS_W'(prod_ff);
                  end
               end
               OP_UPDATE: begin
                  if (remove_ff) begin
                     sbb_ff <= sbb_ff - prod_ff[SQ_W-1:0];
                     st_ff <= st_ff + SUM_W'(t_ff) - SUM_W'(ot_ff);
                     sb_ff <= sb_ff + SUM_W'(b_ff) - SUM_W'(ob_ff);
                  end else begin
                     st_ff <= st_ff + SUM_W'(t_ff);
                     sb_ff <= sb_ff + SUM_W'(b_ff);
                     fill_ff <= fill_ff + 1'b1;
                  end
                  slot_ff <= slot_ff + 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload path, no reset
   always_ff @(posedge clock) begin
      unique case (op)
         OP_ACCEPT: begin
            t_ff <= req_tdata[SAMPLE_W-1:0];
            b_ff <= req_tdata[PAIR_W-1:SAMPLE_W];
         end
         OP_READ: remove_ff <= status.full;
         OP_MUL_TB: begin
            ot_ff <= ram_rdata[SAMPLE_W-1:0];
            ob_ff <= ram_rdata[PAIR_W-1:SAMPLE_W];
            prod_ff <= mul_a * mul_b;
         end
         OP_MUL_BB, OP_MUL_OTB, OP_MUL_OBB: prod_ff <= mul_a * mul_b;
         OP_MUL_SS: begin
            prod_ff <= mul_a * mul_b;
            wprod_ff <= w_s * cross_ff;
         end
         OP_NUM: begin
            num_ff <= wprod_ff - prod_ff;
            prod_ff <= mul_a * mul_b;
            wprod_ff <= w_s * signed'({1'b0, sbb_ff});
         end
         OP_DEN: den_ff <= wprod_ff - prod_ff;
         OP_ABS: begin
            neg_ff <= num_ff[PROD_W-1];
            mag_ff <= num_ff[PROD_W-1] ? (PROD_W'(0) - num_ff) : num_ff;
         end
         OP_INIT: begin
            r_ff <= mag_ff >> FRAC_SHIFT;
            cnt_ff <= '1;
            q_ff <= '0;
         end
         OP_DIV: begin
            r_ff <= ge ? (r_sh - den_ff) : r_sh;
            q_ff <= {q_ff[BETA_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
         end
         OP_FINISH: begin
            rsp_data_ff <= flat ? '0 : beta;
            rsp_user_ff <= {(!flat && sat), flat};
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
endmodule

@@ rtl/core/rolling_beta_window.sv @@
// Rolling beta: each item carries a target and a baseline return (signed Q4.20) and a
// series start flag that empties the window before the item enters it. The block keeps
// the last W pairs (W from csr_wdata, 2..64, below 2 acts as 2, above 64 as 64, reset
// 20; any write also empties the window) and exact sums of t, b, t*b and b*b. Once W
// pairs have entered, each item yields beta = (W*Stb - St*Sb)/(W*Sbb - Sb^2) in Q16.16,
// truncated toward zero and clipped with the saturated flag; a zero baseline variance
// gives beta 0 with flat_baseline set. One item at a time: an item that leaves the
// window still filling ends after the sums update, a flat or early-clipped one skips
// the restoring divider (one quotient bit a cycle, 32 bits); all share one 31x31
// multiplier, and a result waiting on rsp holds only the final step.
module rolling_beta_window import rbw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PAIR_W-1:0]   req_tdata,   // target_return, baseline_return
   input  logic                req_tuser,   // series_start
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [BETA_W-1:0]   rsp_tdata,   // beta
   output logic [1:0]          rsp_tuser,   // flat_baseline, saturated
   input  logic                csr_we,
   input  logic [WLEN_W-1:0]   csr_wdata
);
   op_type     op;
   status_type status;

   // sequencer: one op code per cycle
   rbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .op        (op)
   );

   // window ram, sums, multiplier, divider, output register
   rbw_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // accepted item always starts the window read next
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> op == OP_READ)
      else $error("accept not followed by window read");

   // flat result carries zero beta and no clip
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("flat result malformed");

   // clipped result sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == BETA_POS_MAX || rsp_tdata == BETA_NEG_MAX)
      else $error("saturated beta off limit");

   // no new result while one still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      op == OP_FINISH |-> !(rsp_tvalid && !rsp_tready))
      else $error("result overwritten");
endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
   import rbw_pkg::*;

   localparam string PASS_MSG = "rolling_beta_window verification clean";
   localparam string FAIL_MSG = "rolling_beta_window verification failed";

   // one expected beta result
   typedef struct {
      logic [BETA_W-1:0] beta;
      logic              flat;
      logic              sat;
   } beta_result_type;

   // Scoreboard: holds its own copy of the window and sums, predicts beta per item.
   class beta_scoreboard;
      beta_result_type     pending[$];
      int                  errors;
      int                  result_cnt;
      logic [6:0]          wlen;
      logic signed [23:0]  ring_t[MAX_WINDOW];
      logic signed [23:0]  ring_b[MAX_WINDOW];
      int                  slot;
      int                  fill;
      logic signed [127:0] s_t, s_b, s_tb, s_bb;

      function new();
         errors = 0;
         result_cnt = 0;
         wlen = WLEN_RESET;
         clear_window();
      endfunction

      function void clear_window();
         slot = 0;
         fill = 0;
         s_t = 0;
         s_b = 0;
         s_tb = 0;
         s_bb = 0;
      endfunction

      function void set_length(logic [6:0] v);
         wlen = v;
         clear_window();
      endfunction

      function int span();
         if (wlen < WLEN_MIN) return WLEN_MIN;
         if (wlen > WLEN_MAX) return WLEN_MAX;
         return wlen;
      endfunction

      // note an accepted input item; queue a result when the window is full
      function void note_pair(logic signed [23:0] t, logic signed [23:0] b, logic start);
         int                  w;
         int                  old;
         logic signed [127:0] tt, bb, ot, ob, num, den;
         logic [127:0]        mag, q;
         logic                neg;
         beta_result_type     r;
         w = span();
         if (start) clear_window();
         tt = t;
         bb = b;
         if (fill >= w) begin
            old = (slot + MAX_WINDOW - w) % MAX_WINDOW;
            ot = ring_t[old];
            ob = ring_b[old];
            s_t -= ot;
            s_b -= ob;
            s_tb -= ot * ob;
            s_bb -= ob * ob;
         end else begin
            fill++;
         end
         ring_t[slot] = t;
         ring_b[slot] = b;
         s_t += tt;
         s_b += bb;
         s_tb += tt * bb;
         s_bb += bb * bb;
         slot = (slot + 1) % MAX_WINDOW;
         if (fill < w) return;
         num = w * s_tb - s_t * s_b;
         den = w * s_bb - s_b * s_b;
         r.flat = 0;
         r.sat = 0;
         if (den == 0) begin
            r.beta = 0;
            r.flat = 1;
         end else begin
            neg = num < 0;
            mag = neg ? -num : num;
            q = (mag << FRAC_SHIFT) / den;
            if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
               r.beta = neg ? BETA_NEG_MAX : BETA_POS_MAX;
               r.sat = 1;
            end else begin
               r.beta = neg ? -q[31:0] : q[31:0];
            end
         end
         pending = {pending, r};
      endfunction

      // check one accepted result against the oldest prediction
      function void check_result(logic [BETA_W-1:0] beta, logic [1:0] user);
         beta_result_type e;
         result_cnt++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beta=%h user=%b", $time, beta, user);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (beta !== e.beta) begin
            $display("%0t: beta expected %h actual %h", $time, e.beta, beta);
            errors++;
         end
         if (user[0] !== e.flat) begin
            $display("%0t: flat_baseline expected %b actual %b", $time, e.flat, user[0]);
            errors++;
         end
         if (user[1] !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, user[1]);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [PAIR_W-1:0] req_tdata = '0;
   logic              req_tuser = 0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [BETA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_we = 0;
   logic [WLEN_W-1:0] csr_wdata = '0;

   beta_scoreboard sb = new();

   // idling control: no_idle for both sides, the hold-off for the result side only
   bit no_idle = 0;      // long stretch with no gaps
   bit hold_rsp = 0;     // receiver holds off
   int hold_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   rolling_beta_window i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // result side: random stall, plus the long hold-off counted here
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else if (hold_rsp) begin
         hold_cycles <= 3000;
         hold_rsp <= 0;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 7);
      end
   end

   // offer one item and wait until it is taken; valid stays up for the next item
   task automatic send_pair(logic signed [23:0] t, logic signed [23:0] b, logic start);
      while (!no_idle && $urandom_range(99) < 7) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {b, t};
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      sb.note_pair(t, b, start);
   endtask

   // wait out all results plus the slowest in-flight item
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0 || hold_cycles != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_length(logic [6:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.set_length(v);
   endtask

   function automatic logic signed [23:0] rnd_sample();
      case ($urandom_range(5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'($signed($urandom_range(200)) - 100);
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      logic [6:0] lens[$];
      int         wl;
      int         i;
      int         n;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset length of 20 with a flat baseline, then extremes
      for (i = 0; i < 20; i++) send_pair(24'sh7FFFFF, 24'sh000100, i == 0);
      send_pair(24'sh800000, 24'sh000100, 0);     // still flat
      write_length(0);                             // acts as 2
      send_pair(24'sh7FFFFF, 24'sh000001, 0);
      send_pair(24'sh800000, 24'sh000000, 0);     // steep slope, clipped
      send_pair(24'sh7FFFFF, 24'sh7FFFFF, 0);
      send_pair(24'sh800000, 24'sh800000, 0);
      send_pair(24'sh000001, 24'sh7FFFFF, 1);     // start clears mid-stream
      send_pair(24'sh7FFFFF, 24'sh800000, 0);

      // random phases across lengths, extremes included
      lens = '{7'd127, 7'd64, 7'd2, 7'd1, 7'd65, 7'd3, 7'd8, 7'd5, 7'd4, 7'd16, 7'd2};
      n = 0;
      foreach (lens[k]) begin
         write_length(lens[k]);
         wl = lens[k] < 2 ? 2 : (lens[k] > 64 ? 64 : lens[k]);
         no_idle = (k == 3);
         if (k == 5) hold_rsp = 1;
         for (i = 0; i < (wl > 20 ? 120 : 70); i++) begin
            send_pair(rnd_sample(), ($urandom_range(30) == 0) ? 24'sh000040 : rnd_sample(),
                      $urandom_range(60) == 0);
            n++;
         end
         if (k == 7) drain();   // sender pause until all results are in
      end
      drain();
      if (sb.errors == 0)
         $display(PASS_MSG);
      else
         $display(FAIL_MSG);
      $finish;
   end

   initial begin
      #3000000;
      $display(FAIL_MSG);
      $finish;
   end

endmodule
